[src/gba_pkg.sv]
package gba_pkg;

    localparam int GBA_GRANULES      = 4096;
    localparam int GBA_GRANULE_BYTES = 16;

    // map entries packed per memory word
    localparam int EPW     = 16;
    localparam int ENTRY_W = 2;
    localparam int WORD_W  = EPW * ENTRY_W;

    localparam int REQ_W       = 17;
    localparam int IDX_W       = 12;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    typedef logic [ENTRY_W-1:0] t_entry;

    localparam t_entry ENTRY_FREE  = 2'b00;
    localparam t_entry ENTRY_START = 2'b01;
    localparam t_entry ENTRY_CONT  = 2'b11;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_ROOM,
        ST_ZERO_SIZE,
        ST_NOT_START
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MRD,
        S_MWR,
        S_FREE,
        S_RESP
    } t_state;

endpackage

[src/gba_ram.sv]
module gba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/granule_bitmap_allocator.sv]
// First-fit granule allocator over a 2-bit-per-granule map.
// Input channel (s_axis): one beat is one request. tuser carries the
// operation (allocate or free); tdata carries the byte count and the start
// granule to free. Output channel (m_axis): one beat per request with the
// status and, for a successful allocate, the start granule.
// The map sits in one RAM, 16 entries per word, read one word a cycle.
// Allocate: the byte count is first rounded up to granules (reciprocal
// multiply), then the map is scanned first-fit word by word (256 words
// at 4096 granules), then each word covered by the new run is read,
// marked and written back, and last the result is loaded. Free: the word
// of the start granule is read and cleared, then each further word of
// continuation entries in turn. A zero-size allocate or an out-of-range
// free goes straight to the result, an oversize allocate does so after
// the rounding. One request is in work at a time; tready rises again as
// the result is loaded. After reset the map is cleared by a sweep of one
// word a cycle over all GRANULES/16 words; no beat is taken until it ends.
// The result sits in an output register: a stalled receiver holds it
// there, the next request is still accepted and worked on, and its result
// waits until the register frees up.
module granule_bitmap_allocator #(
    parameter int GRANULES      = gba_pkg::GBA_GRANULES,
    parameter int GRANULE_BYTES = gba_pkg::GBA_GRANULE_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // request_bytes[16:0], start_granule[28:17], zero pad
    input  logic [gba_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[1:0], granule_index[13:2], zero pad
    output logic [gba_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import gba_pkg::*;

    localparam int WORDS = (GRANULES + EPW - 1) / EPW;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GIW   = WAW + 4;
    localparam int CNTW  = $clog2(GRANULES + 1);
    localparam int NUMW  = REQ_W + 1;
    // ceil(2^SH / GRANULE_BYTES) gives an exact quotient for NUMW-bit numerators
    localparam int SH    = NUMW + $clog2(GRANULE_BYTES);
    localparam int RCW   = NUMW + 1;
    localparam int PW    = SH + NUMW;
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(GRANULE_BYTES - 1)) / 64'(GRANULE_BYTES);

    t_state             r_state, n_state;
    logic [WAW-1:0]     r_word, n_word;
    logic [CNTW-1:0]    r_carry, n_carry;
    logic [CNTW-1:0]    r_need, n_need;
    logic [GIW-1:0]     r_start, n_start;
    logic [GIW-1:0]     r_end, n_end;
    logic [3:0]         r_pos, n_pos;
    logic               r_first, n_first;
    logic [NUMW-1:0]    r_num, n_num;
    t_status            r_res_status, n_res_status;
    logic [IDX_W-1:0]   r_res_idx, n_res_idx;
    logic               r_ovalid;
    t_status            r_ostatus;
    logic [IDX_W-1:0]   r_oidx;

    // ram port
    logic               ram_we, ram_re;
    logic [WAW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    // request fields
    logic               in_op;
    logic [REQ_W-1:0]   in_bytes;
    logic [IDX_W-1:0]   in_idx;
    logic               in_fire;
    logic               idx_oor;
    logic [WAW-1:0]     idx_word;

    // granule count
    logic [PW-1:0]      div_prod;
    logic [NUMW-1:0]    div_q;
    logic               need_big;

    // scan
    logic [EPW-1:0]     scan_free;
    logic               scan_hit;
    logic [GIW-1:0]     scan_end;
    logic [GIW-1:0]     scan_start;
    logic               scan_last;

    // mark / free
    logic [WORD_W-1:0]  mark_word;
    logic               mark_last;
    logic [WORD_W-1:0]  free_word;
    logic               free_bad;
    logic               free_more;
    logic               out_free;

    gba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_bytes = s_axis_tdata[REQ_W-1:0];
    assign in_idx   = s_axis_tdata[REQ_W+IDX_W-1:REQ_W];
    assign in_op    = s_axis_tuser;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign idx_oor  = (32'(in_idx) >= GRANULES);
    assign idx_word = WAW'(32'(in_idx) >> 4);
    assign out_free = !r_ovalid || m_axis_tready;

    // round up to granules: multiply by the reciprocal, keep the high bits
    assign div_prod = PW'(r_num) * PW'(RECIP[RCW-1:0]);
    assign div_q    = div_prod[PW-1:SH];
    assign need_big = (32'(div_q) > GRANULES);

    // first-fit scan of one word: running free count per entry
    always_comb begin
        logic [CNTW-1:0] cnt;
        logic [4:0]      run;
        logic            stop;
        logic [GIW-1:0]  g;
        scan_hit   = 1'b0;
        scan_end   = '0;
        scan_start = '0;
        scan_free  = '0;
        for (int k = 0; k < EPW; k++) begin
            g = {r_word, 4'(k)};
            scan_free[k] = (ram_rdata[k*ENTRY_W +: ENTRY_W] == ENTRY_FREE)
                           && (32'(g) < GRANULES);
        end
        for (int k = EPW - 1; k >= 0; k--) begin
            run  = '0;
            stop = 1'b0;
            for (int j = k; j >= 0; j--) begin
                if (!stop) begin
                    if (scan_free[j]) begin
                        run = run + 5'd1;
                    end else begin
                        stop = 1'b1;
                    end
                end
            end
            cnt = stop ? CNTW'(run) : (r_carry + CNTW'(run));
            g   = {r_word, 4'(k)};
            // walk downward so the lowest hit wins
            if (scan_free[k] && (cnt >= r_need)) begin
                scan_hit   = 1'b1;
                scan_end   = g;
                scan_start = GIW'(32'(g) - 32'(r_need) + 32'd1);
            end
        end
    end

    assign scan_last = (r_word == WAW'(WORDS - 1));

    // carry of free entries into the next word
    always_comb begin
        logic [4:0] run;
        logic       stop;
        run  = '0;
        stop = 1'b0;
        for (int j = EPW - 1; j >= 0; j--) begin
            if (!stop) begin
                if (scan_free[j]) begin
                    run = run + 5'd1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        n_carry = stop ? CNTW'(run) : (r_carry + CNTW'(run));
    end

    // mark the new run inside the current word
    always_comb begin
        logic [GIW-1:0] g;
        mark_word = ram_rdata;
        for (int k = 0; k < EPW; k++) begin
            g = {r_word, 4'(k)};
            if (g == r_start) begin
                mark_word[k*ENTRY_W +: ENTRY_W] = ENTRY_START;
            end else if ((g > r_start) && (g <= r_end)) begin
                mark_word[k*ENTRY_W +: ENTRY_W] = ENTRY_CONT;
            end
        end
    end

    assign mark_last = (r_word == r_end[GIW-1:4]);

    // clear start plus following continuation entries
    always_comb begin
        logic going;
        going     = 1'b1;
        free_word = ram_rdata;
        free_bad  = r_first &&
                    (ram_rdata[r_pos*ENTRY_W +: ENTRY_W] != ENTRY_START);
        for (int k = 0; k < EPW; k++) begin
            if (r_first && (4'(k) < r_pos)) begin
                going = going;
            end else if (r_first && (4'(k) == r_pos)) begin
                free_word[k*ENTRY_W +: ENTRY_W] = ENTRY_FREE;
            end else begin
                going = going && (ram_rdata[k*ENTRY_W +: ENTRY_W] == ENTRY_CONT);
                if (going) begin
                    free_word[k*ENTRY_W +: ENTRY_W] = ENTRY_FREE;
                end
            end
        end
        free_more = going && !scan_last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_ALLOC) begin
                        n_state = (in_bytes == '0) ? S_RESP : S_DIV;
                    end else begin
                        n_state = idx_oor ? S_RESP : S_FREE;
                    end
                end
            end
            S_DIV: begin
                n_state = need_big ? S_RESP : S_SCAN;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_MRD;
                end else if (scan_last) begin
                    n_state = S_RESP;
                end
            end
            S_MRD: n_state = S_MWR;
            S_MWR: n_state = mark_last ? S_RESP : S_MRD;
            S_FREE: begin
                if (free_bad || !free_more) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_word       = r_word;
        n_need       = r_need;
        n_start      = r_start;
        n_end        = r_end;
        n_pos        = r_pos;
        n_first      = r_first;
        n_num        = r_num;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        ram_we       = 1'b0;
        ram_waddr    = r_word;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_word;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_word = r_word + WAW'(1);
            end
            S_IDLE: begin
                n_res_idx = '0;
                if (in_fire) begin
                    if (in_op == OP_ALLOC) begin
                        n_res_status = ST_ZERO_SIZE;
                        n_num  = NUMW'(in_bytes) + NUMW'(GRANULE_BYTES - 1);
                    end else begin
                        n_res_status = ST_NOT_START;
                        n_word    = idx_word;
                        n_pos     = in_idx[3:0];
                        n_first   = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = idx_word;
                    end
                end
            end
            S_DIV: begin
                n_res_status = ST_NO_ROOM;
                n_need    = CNTW'(div_q);
                n_word    = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_start = scan_start;
                    n_end   = scan_end;
                    n_word  = scan_start[GIW-1:4];
                end else if (!scan_last) begin
                    n_word    = r_word + WAW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = r_word + WAW'(1);
                end
            end
            S_MRD: begin
                ram_re = 1'b1;
            end
            S_MWR: begin
                ram_we    = 1'b1;
                ram_wdata = mark_word;
                if (mark_last) begin
                    n_res_status = ST_OK;
                    n_res_idx    = IDX_W'(32'(r_start));
                end else begin
                    n_word = r_word + WAW'(1);
                end
            end
            S_FREE: begin
                if (!free_bad) begin
                    ram_we       = 1'b1;
                    ram_wdata    = free_word;
                    n_res_status = ST_OK;
                    if (free_more) begin
                        n_word    = r_word + WAW'(1);
                        n_first   = 1'b0;
                        ram_re    = 1'b1;
                        ram_raddr = r_word + WAW'(1);
                    end
                end
            end
            S_RESP: begin
                n_word = r_word;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_word   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            // load the result when the output register frees up
            if (r_state == S_RESP && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry      <= (r_state == S_SCAN) ? n_carry : '0;
        r_need       <= n_need;
        r_start      <= n_start;
        r_end        <= n_end;
        r_pos        <= n_pos;
        r_first      <= n_first;
        r_num        <= n_num;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        if (r_state == S_RESP && out_free) begin
            r_ostatus <= r_res_status;
            r_oidx    <= r_res_idx;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oidx, r_ostatus};

endmodule
